// ----- hdl/dnsa_pkg.sv -----
// Shared types for the DNS response A-record extractor.
// Holds the status codes and the result structure; depends on nothing.
`default_nettype none

package dnsa_pkg;

   localparam int DataWidth    = 8;
   localparam int AddrWidth    = 32;
   localparam int StatusWidth  = 3;
   localparam int CountWidth   = 16;
   localparam int RspDataWidth = 40;

   typedef enum logic [StatusWidth-1:0] {
      ST_FOUND   = 3'd0,
      ST_BADHDR  = 3'd1,
      ST_BADNAME = 3'd2,
      ST_TRUNC   = 3'd3,
      ST_BADLEN  = 3'd4,
      ST_NOREC   = 3'd5
   } status_type;

   typedef struct packed {
      status_type           status;
      logic [AddrWidth-1:0] address;
   } result_type;

endpackage

`default_nettype wire

// ----- hdl/dnsa_parser.sv -----
// Byte-wise DNS message parser: header checks, question skip and answer walk.
// Depends on dnsa_pkg for the status codes and the result structure.
`default_nettype none

module dnsa_parser (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           accept,
   input  wire logic [dnsa_pkg::DataWidth-1:0] data_byte,
   input  wire logic                           last_byte,
   output dnsa_pkg::result_type                result
);
   import dnsa_pkg::*;

   typedef enum logic [8:0] {
      PH_HEADER = 9'b000000001,
      PH_QNAME  = 9'b000000010,
      PH_QLABEL = 9'b000000100,
      PH_QPTR   = 9'b000001000,
      PH_QTAIL  = 9'b000010000,
      PH_ANS    = 9'b000100000,
      PH_RDATA  = 9'b001000000,
      PH_ADDR   = 9'b010000000,
      PH_DONE   = 9'b100000000
   } phase_type;

   phase_type             phase_ff,        phase_in;
   logic [3:0]            byte_pos_ff,     byte_pos_in;
   logic [CountWidth-1:0] qcount_ff,       qcount_in;
   logic [CountWidth-1:0] acount_ff,       acount_in;
   logic [CountWidth-1:0] rec_index_ff,    rec_index_in;
   logic [CountWidth-1:0] skip_ff,         skip_in;
   logic                  type_hi_zero_ff, type_hi_zero_in;
   logic                  type_is_a_ff,    type_is_a_in;
   logic                  class_hi_zero_ff, class_hi_zero_in;
   logic                  class_is_in_ff,  class_is_in_in;
   logic [DataWidth-1:0]  len_hi_ff,       len_hi_in;
   logic [AddrWidth-1:0]  address_ff,      address_in;
   status_type            status_ff,       status_in;

   logic [CountWidth-1:0] rec_index_inc;
   logic [CountWidth-1:0] data_len;
   logic                  skip_last;

   assign rec_index_inc = rec_index_ff + 16'd1;
   assign data_len      = {len_hi_ff, data_byte};
   assign skip_last     = (skip_ff == 16'd1);

   always_comb begin
      phase_in         = phase_ff;
      byte_pos_in      = byte_pos_ff;
      qcount_in        = qcount_ff;
      acount_in        = acount_ff;
      rec_index_in     = rec_index_ff;
      skip_in          = skip_ff;
      type_hi_zero_in  = type_hi_zero_ff;
      type_is_a_in     = type_is_a_ff;
      class_hi_zero_in = class_hi_zero_ff;
      class_is_in_in   = class_is_in_ff;
      len_hi_in        = len_hi_ff;
      address_in       = address_ff;
      status_in        = status_ff;

      case (phase_ff)
         PH_HEADER: begin
            byte_pos_in = byte_pos_ff + 4'd1;
            case (byte_pos_ff)
               4'd2: begin
                  if (!data_byte[7]) begin
                     status_in = ST_BADHDR;
                     phase_in  = PH_DONE;
                  end
               end
               4'd3: begin
                  if (data_byte[3:0] != 4'd0) begin
                     status_in = ST_BADHDR;
                     phase_in  = PH_DONE;
                  end
               end
               4'd4: qcount_in = {data_byte, 8'd0};
               4'd5: qcount_in = {qcount_ff[15:8], data_byte};
               4'd6: acount_in = {data_byte, 8'd0};
               4'd7: begin
                  acount_in = {acount_ff[15:8], data_byte};
                  if ({acount_ff[15:8], data_byte} == 16'd0) begin
                     status_in = ST_BADHDR;
                     phase_in  = PH_DONE;
                  end
               end
               4'd11: begin
                  rec_index_in = '0;
                  byte_pos_in  = 4'd0;
                  if (qcount_ff == 16'd0) begin
                     phase_in = PH_ANS;
                  end else begin
                     phase_in = PH_QNAME;
                  end
               end
               default: ;
            endcase
         end
         PH_QNAME: begin
            if (data_byte == 8'd0) begin
               skip_in  = 16'd4;
               phase_in = PH_QTAIL;
            end else if (data_byte[7:6] == 2'b11) begin
               phase_in = PH_QPTR;
            end else begin
               skip_in  = {8'd0, data_byte};
               phase_in = PH_QLABEL;
            end
         end
         PH_QLABEL: begin
            skip_in = skip_ff - 16'd1;
            if (skip_last) begin
               phase_in = PH_QNAME;
            end
         end
         PH_QPTR: begin
            skip_in  = 16'd4;
            phase_in = PH_QTAIL;
         end
         PH_QTAIL: begin
            skip_in = skip_ff - 16'd1;
            if (skip_last) begin
               // Question finished: move on to the next one or to the answers.
               if (rec_index_inc == qcount_ff) begin
                  rec_index_in = '0;
                  byte_pos_in  = 4'd0;
                  phase_in     = PH_ANS;
               end else begin
                  rec_index_in = rec_index_inc;
                  phase_in     = PH_QNAME;
               end
            end
         end
         PH_ANS: begin
            byte_pos_in = byte_pos_ff + 4'd1;
            case (byte_pos_ff)
               4'd0: begin
                  if (data_byte[7:6] != 2'b11) begin
                     status_in = ST_BADNAME;
                     phase_in  = PH_DONE;
                  end
               end
               4'd2: type_hi_zero_in  = (data_byte == 8'd0);
               4'd3: type_is_a_in     = type_hi_zero_ff && (data_byte == 8'd1);
               4'd4: class_hi_zero_in = (data_byte == 8'd0);
               4'd5: class_is_in_in   = class_hi_zero_ff && (data_byte == 8'd1);
               4'd10: len_hi_in = data_byte;
               4'd11: begin
                  byte_pos_in = byte_pos_ff;
                  if (type_is_a_ff && class_is_in_ff) begin
                     if (data_len != 16'd4) begin
                        status_in = ST_BADLEN;
                        phase_in  = PH_DONE;
                     end else begin
                        address_in = '0;
                        skip_in    = 16'd4;
                        phase_in   = PH_ADDR;
                     end
                  end else if (data_len == 16'd0) begin
                     rec_index_in = rec_index_inc;
                     if (rec_index_inc == acount_ff) begin
                        status_in = ST_NOREC;
                        phase_in  = PH_DONE;
                     end else begin
                        byte_pos_in = 4'd0;
                     end
                  end else begin
                     skip_in  = data_len;
                     phase_in = PH_RDATA;
                  end
               end
               default: ;
            endcase
         end
         PH_RDATA: begin
            skip_in = skip_ff - 16'd1;
            if (skip_last) begin
               rec_index_in = rec_index_inc;
               if (rec_index_inc == acount_ff) begin
                  status_in = ST_NOREC;
                  phase_in  = PH_DONE;
               end else begin
                  byte_pos_in = 4'd0;
                  phase_in    = PH_ANS;
               end
            end
         end
         PH_ADDR: begin
            address_in = {address_ff[AddrWidth-DataWidth-1:0], data_byte};
            skip_in    = skip_ff - 16'd1;
            if (skip_last) begin
               status_in = ST_FOUND;
               phase_in  = PH_DONE;
            end
         end
         PH_DONE: ;
         default: ;
      endcase
   end

   // The result reflects the state after this byte has been taken.
   always_comb begin
      result.status  = (phase_in == PH_DONE) ? status_in : ST_TRUNC;
      result.address = (result.status == ST_FOUND) ? address_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         byte_pos_ff <= 4'd0;
      end else if (accept) begin
         if (last_byte) begin
            phase_ff    <= PH_HEADER;
            byte_pos_ff <= 4'd0;
         end else begin
            phase_ff    <= phase_in;
            byte_pos_ff <= byte_pos_in;
         end
      end
   end

   // Every field below is written before it is read within a message.
   always_ff @(posedge clock) begin
      if (accept) begin
         qcount_ff        <= qcount_in;
         acount_ff        <= acount_in;
         rec_index_ff     <= rec_index_in;
         skip_ff          <= skip_in;
         type_hi_zero_ff  <= type_hi_zero_in;
         type_is_a_ff     <= type_is_a_in;
         class_hi_zero_ff <= class_hi_zero_in;
         class_is_in_ff   <= class_is_in_in;
         len_hi_ff        <= len_hi_in;
         address_ff       <= address_in;
         status_ff        <= status_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/dnsa_out_reg.sv -----
// Result register for the DNS response A-record extractor.
// Depends on dnsa_pkg for the result structure and the result data width.
`default_nettype none

module dnsa_out_reg (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              load,
   input  wire dnsa_pkg::result_type              result,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [dnsa_pkg::RspDataWidth-1:0]      rsp_tdata
);
   import dnsa_pkg::*;

   logic       valid_ff;
   result_type data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RspDataWidth - AddrWidth - StatusWidth){1'b0}},
                        data_ff.address, data_ff.status};

endmodule

`default_nettype wire

// ----- hdl/dns_response_a_record_extract_core.sv -----
// Top level of the DNS response A-record extractor.
// Instantiates dnsa_parser and dnsa_out_reg; depends on dnsa_pkg.
//
// The block takes a DNS response one byte per transaction on the req_ side,
// with req_tlast on the final byte of the message. It checks the 12-byte
// header, skips the questions, walks the answer records (whose names must
// be compression pointers) and captures the first IN A record, which must
// have length four. On the transaction that carries the final byte it
// produces exactly one result transaction on the rsp_ side: a status code
// and the address, which reads zero unless the status is found. The parser
// state is updated in a single step per byte and the result is held in one
// output register, so a byte may be accepted in every cycle. Only a final
// byte waits, and only while the previous result is still held and not
// being taken; ordinary bytes keep flowing meanwhile. After the final byte
// the parser returns to its initial state, ready for the next message.
`default_nettype none

module dns_response_a_record_extract_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Request channel: tdata[7:0] data_byte; tlast is last_byte.
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [dnsa_pkg::DataWidth-1:0]    req_tdata,
   input  wire logic                              req_tlast,
   // Response channel: tdata[2:0] status, tdata[34:3] address, rest zero.
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [dnsa_pkg::RspDataWidth-1:0]      rsp_tdata
);
   import dnsa_pkg::*;

   logic       accept;
   logic       load;
   result_type result;

   // A final byte needs the result register to be free or being emptied.
   assign req_tready = !req_tlast || !rsp_tvalid || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign load       = accept && req_tlast;

   dnsa_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .result    (result)
   );

   dnsa_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .result     (result),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Testbench for dns_response_a_record_extract_core: walks directed and random DNS responses
// through the byte stream and checks every status/address result against a local model or a table row.
// Depends on dnsa_pkg for the status codes and the result layout.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dnsa_pkg::*;

   localparam int CycleLimit   = 600000;
   localparam int RandomBytes  = 1000;
   localparam int SettleCycles = 8;

   // Walk position of the local parser model. These mirror how the block moves
   // through the header, the question section and the answer records.
   typedef enum logic [3:0] {
      WALK_HEADER, WALK_QNAME, WALK_QLABEL, WALK_QPTR, WALK_QTAIL,
      WALK_ANSWER, WALK_RDATA, WALK_ADDR, WALK_DONE
   } walk_phase_type;

   // One row of the directed header table. A row flagged as typed carries a
   // hand-written expectation; the other rows rely on the parser model.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       typed;
      status_type status;
   } header_row_type;

   localparam int HeaderRowCount = 22;
   localparam header_row_type HeaderRows [HeaderRowCount] = '{
      // A lone final byte straight after reset: nothing decided, so truncated.
      '{8'hFF, 1'b1, 1'b1, ST_TRUNC},
      // QR bit clear in the flags byte; the bytes after it are ignored.
      '{8'h12, 1'b0, 1'b0, ST_FOUND},
      '{8'h34, 1'b0, 1'b0, ST_FOUND},
      '{8'h7F, 1'b0, 1'b0, ST_FOUND},
      '{8'h80, 1'b0, 1'b0, ST_FOUND},
      '{8'h00, 1'b1, 1'b1, ST_BADHDR},
      // QR set but a non-zero RCODE.
      '{8'hFF, 1'b0, 1'b0, ST_FOUND},
      '{8'hFF, 1'b0, 1'b0, ST_FOUND},
      '{8'h80, 1'b0, 1'b0, ST_FOUND},
      '{8'h01, 1'b1, 1'b1, ST_BADHDR},
      // Clean flags, one question, but an answer count of zero.
      '{8'hAB, 1'b0, 1'b0, ST_FOUND},
      '{8'hCD, 1'b0, 1'b0, ST_FOUND},
      '{8'h81, 1'b0, 1'b0, ST_FOUND},
      '{8'h80, 1'b0, 1'b0, ST_FOUND},
      '{8'h00, 1'b0, 1'b0, ST_FOUND},
      '{8'h01, 1'b0, 1'b0, ST_FOUND},
      '{8'h00, 1'b0, 1'b0, ST_FOUND},
      '{8'h00, 1'b1, 1'b1, ST_BADHDR},
      // A clean header cut short: truncated.
      '{8'h00, 1'b0, 1'b0, ST_FOUND},
      '{8'h00, 1'b0, 1'b0, ST_FOUND},
      '{8'h80, 1'b0, 1'b0, ST_FOUND},
      '{8'h00, 1'b1, 1'b1, ST_TRUNC}
   };

   logic clock;
   logic reset = 1'b1;

   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [DataWidth-1:0]    req_tdata  = '0;    // [7:0] data_byte
   logic                    req_tlast  = 1'b0;  // last_byte
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;          // [2:0] status, [34:3] address, rest zero

   // Travels alongside each request transaction: when set, the typed result
   // below replaces the model's prediction for that final byte.
   logic       req_typed = 1'b0;
   result_type typed_rsp = '0;

   dns_response_a_record_extract_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Parser model. It keeps its own copy of the walk state and is stepped once
   // per accepted request transaction.
   // ------------------------------------------------------------------------
   walk_phase_type walk;
   logic [15:0] field_pos;
   logic [15:0] questions_total;
   logic [15:0] answers_total;
   logic [15:0] record_no;
   logic [15:0] bytes_to_skip;
   logic [15:0] rr_type;
   logic [15:0] rr_class;
   logic [15:0] rr_length;
   logic [31:0] address_acc;
   status_type  verdict;
   logic        verdict_made;

   task automatic restart_walk();
      walk            = WALK_HEADER;
      field_pos       = '0;
      questions_total = '0;
      answers_total   = '0;
      record_no       = '0;
      bytes_to_skip   = '0;
      rr_type         = '0;
      rr_class        = '0;
      rr_length       = '0;
      address_acc     = '0;
      verdict         = ST_TRUNC;
      verdict_made    = 1'b0;
   endtask

   // Once a verdict is made, every further byte of the message is ignored.
   task automatic settle(input status_type s);
      verdict      = s;
      verdict_made = 1'b1;
      walk         = WALK_DONE;
   endtask

   task automatic start_answers();
      record_no = '0;
      field_pos = '0;
      walk      = WALK_ANSWER;
   endtask

   task automatic finish_question();
      record_no = record_no + 16'd1;
      if (record_no == questions_total) start_answers();
      else walk = WALK_QNAME;
   endtask

   task automatic finish_answer();
      record_no = record_no + 16'd1;
      if (record_no == answers_total) begin
         settle(ST_NOREC);
      end else begin
         field_pos = '0;
         walk      = WALK_ANSWER;
      end
   endtask

   task automatic parse_byte(input logic [7:0] b);
      case (walk)
         WALK_HEADER: begin
            // The first header fault seen decides the message.
            if (field_pos == 16'd2 && !b[7]) begin
               settle(ST_BADHDR);
            end else if (field_pos == 16'd3 && b[3:0] != 4'h0) begin
               settle(ST_BADHDR);
            end else if (field_pos == 16'd7 && {answers_total[15:8], b} == 16'd0) begin
               settle(ST_BADHDR);
            end else begin
               case (field_pos)
                  16'd4: questions_total = {b, 8'h00};
                  16'd5: questions_total = {questions_total[15:8], b};
                  16'd6: answers_total   = {b, 8'h00};
                  16'd7: answers_total   = {answers_total[15:8], b};
                  default: ;
               endcase
               if (field_pos == 16'd11) begin
                  record_no = '0;
                  // With no questions the answers begin right after the header.
                  if (questions_total == 16'd0) start_answers();
                  else walk = WALK_QNAME;
               end else begin
                  field_pos = field_pos + 16'd1;
               end
            end
         end
         WALK_QNAME: begin
            // A root byte or a pointer ends the name; anything else, including
            // the reserved lengths 0x40 to 0xBF, is a plain label length.
            if (b == 8'h00) begin
               bytes_to_skip = 16'd4;
               walk          = WALK_QTAIL;
            end else if (b[7:6] == 2'b11) begin
               walk = WALK_QPTR;
            end else begin
               bytes_to_skip = {8'h00, b};
               walk          = WALK_QLABEL;
            end
         end
         WALK_QLABEL: begin
            bytes_to_skip = bytes_to_skip - 16'd1;
            if (bytes_to_skip == 16'd0) walk = WALK_QNAME;
         end
         WALK_QPTR: begin
            bytes_to_skip = 16'd4;
            walk          = WALK_QTAIL;
         end
         WALK_QTAIL: begin
            bytes_to_skip = bytes_to_skip - 16'd1;
            if (bytes_to_skip == 16'd0) finish_question();
         end
         WALK_ANSWER: begin
            if (field_pos == 16'd0 && b[7:6] != 2'b11) begin
               settle(ST_BADNAME);
            end else begin
               case (field_pos)
                  16'd2:  rr_type   = {b, 8'h00};
                  16'd3:  rr_type   = {rr_type[15:8], b};
                  16'd4:  rr_class  = {b, 8'h00};
                  16'd5:  rr_class  = {rr_class[15:8], b};
                  16'd10: rr_length = {b, 8'h00};
                  16'd11: rr_length = {rr_length[15:8], b};
                  default: ;
               endcase
               if (field_pos == 16'd11) begin
                  if (rr_type == 16'd1 && rr_class == 16'd1) begin
                     if (rr_length != 16'd4) begin
                        settle(ST_BADLEN);
                     end else begin
                        address_acc   = '0;
                        bytes_to_skip = 16'd4;
                        walk          = WALK_ADDR;
                     end
                  end else if (rr_length == 16'd0) begin
                     finish_answer();
                  end else begin
                     bytes_to_skip = rr_length;
                     walk          = WALK_RDATA;
                  end
               end else begin
                  field_pos = field_pos + 16'd1;
               end
            end
         end
         WALK_RDATA: begin
            bytes_to_skip = bytes_to_skip - 16'd1;
            if (bytes_to_skip == 16'd0) finish_answer();
         end
         WALK_ADDR: begin
            address_acc   = {address_acc[23:0], b};
            bytes_to_skip = bytes_to_skip - 16'd1;
            if (bytes_to_skip == 16'd0) settle(ST_FOUND);
         end
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Checking. Predictions are pushed on accepted final bytes and consumed in
   // order by accepted response transactions, all within one clocked block so
   // that both happen in a fixed order at each edge.
   // ------------------------------------------------------------------------
   result_type expected_results[$];
   int         mismatch_count = 0;
   int         bytes_taken    = 0;
   int         results_seen   = 0;
   int         status_tally [6];
   longint     cycle_count    = 0;

   task automatic report_mismatch(input string what, input logic [39:0] want,
                                  input logic [39:0] got);
      mismatch_count++;
      $display("MISMATCH at %0t: %s, expected %0h, got %0h", $time, what, want, got);
   endtask

   always @(posedge clock) begin
      result_type want;
      result_type predicted;
      if (reset) begin
         restart_walk();
      end else begin
         if (req_tvalid && req_tready) begin
            bytes_taken++;
            parse_byte(req_tdata);
            if (req_tlast) begin
               predicted.status  = verdict_made ? verdict : ST_TRUNC;
               predicted.address = (predicted.status == ST_FOUND) ? address_acc : '0;
               expected_results.push_back(req_typed ? typed_rsp : predicted);
               // The block is ready for a fresh message after a final byte.
               restart_walk();
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing outstanding", '0, rsp_tdata);
            end else begin
               want = expected_results.pop_front();
               results_seen++;
               if (want.status <= ST_NOREC) status_tally[want.status]++;
               if (rsp_tdata[StatusWidth-1:0] !== want.status)
                  report_mismatch("status", 40'(want.status), 40'(rsp_tdata[StatusWidth-1:0]));
               if (rsp_tdata[StatusWidth +: AddrWidth] !== want.address)
                  report_mismatch("address", 40'(want.address),
                                  40'(rsp_tdata[StatusWidth +: AddrWidth]));
               if (rsp_tdata[RspDataWidth-1:StatusWidth+AddrWidth] !== '0)
                  report_mismatch("padding bits", '0, rsp_tdata);
            end
         end
      end
   end

   // A run that stops making progress ends here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Response side back-pressure: mostly short stalls, a few long ones, and
   // calm stretches where the result is always taken at once.
   // ------------------------------------------------------------------------
   int  stall_left = 0;
   bit  rsp_calm   = 1'b0;

   always @(posedge clock) begin
      int pick;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if ($urandom_range(0, 299) == 0) rsp_calm = ~rsp_calm;
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            pick = $urandom_range(0, 99);
            if (!rsp_calm) begin
               if (pick < 20) stall_left = $urandom_range(1, 3);
               else if (pick < 23) stall_left = $urandom_range(10, 40);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request side: message builders and the byte driver.
   // ------------------------------------------------------------------------
   logic [7:0] msg_bytes[$];
   bit         req_calm       = 1'b0;
   int         messages_sent  = 0;
   int         random_bytes   = 0;

   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (req_calm || pick < 65) return 0;
      if (pick < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Drives one byte and holds it until the block takes it. When no gap is
   // drawn, req_tvalid simply stays high into the next transaction.
   task automatic send_byte(input logic [7:0] b, input bit last, input bit typed,
                            input result_type want);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      req_typed  <= typed;
      typed_rsp  <= want;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_message();
      if ($urandom_range(0, 7) == 0) req_calm = ~req_calm;
      for (int i = 0; i < msg_bytes.size(); i++)
         send_byte(msg_bytes[i], i == msg_bytes.size() - 1, 1'b0, '0);
      messages_sent++;
   endtask

   // Holds the request side idle until every outstanding result has arrived.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic put16(input logic [15:0] v);
      msg_bytes.push_back(v[15:8]);
      msg_bytes.push_back(v[7:0]);
   endtask

   // Builds a DNS response. a_slot picks the answer that is the IN A record
   // (-1 for none), a_len its RDLENGTH, bad_slot an answer whose name is not a
   // pointer (-1 for none). hdr_answers is the count written in the header.
   task automatic build_response(input int n_quest, input int n_ans, input int hdr_answers,
                                 input int a_slot, input int a_len, input int bad_slot,
                                 input bit wide_label, input bit ptr_tail);
      int          labels;
      int          len;
      logic [15:0] rtype;
      logic [15:0] rclass;
      logic [15:0] rdlen;
      msg_bytes.delete();
      put16(16'($urandom));
      msg_bytes.push_back({1'b1, 7'($urandom)});
      msg_bytes.push_back({4'($urandom), 4'h0});
      put16(16'(n_quest));
      put16(16'(hdr_answers));
      put16(16'($urandom));
      put16(16'($urandom));
      for (int q = 0; q < n_quest; q++) begin
         labels = $urandom_range(0, 3);
         if (wide_label && labels == 0) labels = 1;
         for (int l = 0; l < labels; l++) begin
            len = (wide_label && l == 0) ? $urandom_range(64, 191) : $urandom_range(1, 10);
            msg_bytes.push_back(8'(len));
            repeat (len) msg_bytes.push_back(8'($urandom));
         end
         if (ptr_tail) begin
            msg_bytes.push_back({2'b11, 6'($urandom)});
            msg_bytes.push_back(8'($urandom));
         end else begin
            msg_bytes.push_back(8'h00);
         end
         put16(16'($urandom));
         put16(16'($urandom));
      end
      for (int a = 0; a < n_ans; a++) begin
         if (a == bad_slot) msg_bytes.push_back(8'($urandom_range(0, 191)));
         else msg_bytes.push_back({2'b11, 6'($urandom)});
         msg_bytes.push_back(8'($urandom));
         if (a == a_slot) begin
            rtype  = 16'd1;
            rclass = 16'd1;
            rdlen  = 16'(a_len);
         end else begin
            case ($urandom_range(0, 3))
               0:       rtype = 16'd1;
               1:       rtype = 16'd28;
               2:       rtype = 16'd5;
               default: rtype = 16'($urandom);
            endcase
            rclass = $urandom_range(0, 1) ? 16'd1 : 16'($urandom);
            if (rtype == 16'd1 && rclass == 16'd1) rclass = 16'd3;
            rdlen = 16'($urandom_range(0, 12));
         end
         put16(rtype);
         put16(rclass);
         put16(16'($urandom));
         put16(16'($urandom));
         put16(rdlen);
         repeat (int'(rdlen)) msg_bytes.push_back(8'($urandom));
      end
   endtask

   // Mostly well-formed responses with random content; the rest are cut
   // short, have one bit flipped, carry trailing junk, or are pure noise.
   task automatic build_random_message();
      int n_quest;
      int n_ans;
      int hdr_answers;
      int pick;
      int idx;
      pick = $urandom_range(0, 99);
      if (pick < 20) n_quest = 0;
      else if (pick < 80) n_quest = 1;
      else n_quest = $urandom_range(2, 3);
      n_ans = $urandom_range(1, 4);
      hdr_answers = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n_ans + 2) : n_ans;
      build_response(n_quest, n_ans, hdr_answers,
                     ($urandom_range(0, 3) != 0) ? $urandom_range(0, n_ans - 1) : -1,
                     ($urandom_range(0, 9) != 0) ? 4 : $urandom_range(0, 12),
                     ($urandom_range(0, 19) == 0) ? $urandom_range(0, n_ans - 1) : -1,
                     $urandom_range(0, 19) == 0,
                     $urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         idx = $urandom_range(1, msg_bytes.size() - 1);
         while (msg_bytes.size() > idx) void'(msg_bytes.pop_back());
      end else if (pick < 22) begin
         idx = $urandom_range(0, msg_bytes.size() - 1);
         msg_bytes[idx] = msg_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
      end else if (pick < 30) begin
         msg_bytes.delete();
         repeat ($urandom_range(1, 30)) msg_bytes.push_back(8'($urandom));
      end else if (pick < 38) begin
         repeat ($urandom_range(1, 6)) msg_bytes.push_back(8'($urandom));
      end
   endtask

   initial begin
      result_type     want;
      header_row_type row;
      int             start_bytes;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed header cases from the table, with hand-written expectations
      // on their final bytes.
      for (int r = 0; r < HeaderRowCount; r++) begin
         row          = HeaderRows[r];
         want.status  = row.status;
         want.address = '0;
         send_byte(row.data, row.last, row.typed, want);
      end

      // One message for each outcome of the answer walk: found, no questions,
      // a pointer ending a question name after a reserved-length label, no A
      // record, an A record of the wrong length and a non-pointer answer name.
      build_response(1, 1, 1, 0, 4, -1, 1'b0, 1'b0);
      send_message();
      build_response(0, 2, 2, 1, 4, -1, 1'b0, 1'b0);
      send_message();
      build_response(2, 2, 2, 0, 4, -1, 1'b1, 1'b1);
      send_message();
      build_response(1, 3, 3, -1, 4, -1, 1'b0, 1'b0);
      send_message();
      build_response(1, 2, 2, 1, 6, -1, 1'b0, 1'b0);
      send_message();
      build_response(1, 2, 2, 1, 4, 0, 1'b0, 1'b0);
      send_message();
      drain_results();

      start_bytes = bytes_taken;
      while (random_bytes < RandomBytes) begin
         build_random_message();
         send_message();
         if (messages_sent % 20 == 0) drain_results();
         random_bytes = bytes_taken - start_bytes;
      end

      drain_results();
      repeat (SettleCycles) @(posedge clock);

      $display("Covered %0d messages, %0d bytes and %0d results under random stalls.",
               messages_sent, bytes_taken, results_seen);
      $display("Outcomes: found %0d, bad header %0d, bad name %0d, truncated %0d, %s %0d, %s %0d.",
               status_tally[ST_FOUND], status_tally[ST_BADHDR], status_tally[ST_BADNAME],
               status_tally[ST_TRUNC], "bad length", status_tally[ST_BADLEN],
               "no A record", status_tally[ST_NOREC]);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

`default_nettype wire
